// ----- src/gdad_pkg.sv -----
package gdad_pkg;

	localparam int unsigned MAX_DELTA_DEF = 32767;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DELTA_W = 16;
	localparam int STEP_W  = 16;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
	localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

	localparam logic [DAY_W-1:0] DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0] DAY_31    = 5'd31;
	localparam logic [DAY_W-1:0] DAY_30    = 5'd30;
	localparam logic [DAY_W-1:0] DAY_29    = 5'd29;
	localparam logic [DAY_W-1:0] DAY_28    = 5'd28;

	// Multiplicative inverse of 25 modulo 2**14 and the largest product that
	// marks an exact multiple of 25.
	localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               backward;
		logic [STEP_W-1:0]  steps;
		logic               ok;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} back_state_t;

	// Divisible by 100 means divisible by 4 and by 25; by 400 means by 16 and 25.
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [YEAR_W-1:0] prod;
		logic              div25;
		prod  = YEAR_W'(y * INV25);
		div25 = (prod <= DIV25_MAX);
		return (y[1:0] == 2'b00) && !(div25 && (y[3:0] != 4'b0000));
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] n;
		n = DAY_31;
		if (m == MONTH_FEB) begin
			n = leap ? DAY_29 : DAY_28;
		end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
				m == MONTH_NOV) begin
			n = DAY_30;
		end
		return n;
	endfunction

endpackage

// ----- src/gdad_front.sv -----
module gdad_front
	import gdad_pkg::*;
#(
	parameter int unsigned MAX_DELTA = MAX_DELTA_DEF
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// start_day[4:0], start_month[8:5], start_year[22:9], day_delta[38:23], zero[39]
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 queue_full,
	output logic                 push,
	output job_t                 job
);

	logic [DAY_W-1:0]   d;
	logic [MONTH_W-1:0] m;
	logic [YEAR_W-1:0]  y;
	logic [DELTA_W-1:0] delta;
	logic [STEP_W-1:0]  mag;
	logic               date_ok;

	assign d     = s_tdata[4:0];
	assign m     = s_tdata[8:5];
	assign y     = s_tdata[22:9];
	assign delta = s_tdata[38:23];

	assign s_tready = !queue_full;
	assign push     = s_tvalid && !queue_full;

	always_comb begin
		date_ok = (d != '0) && (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
			(y >= YEAR_MIN) && (y <= YEAR_MAX) && (d <= month_days(m, is_leap(y)));
		// Two's complement negate; the most negative count gives 0x8000 as wanted.
		mag = delta[DELTA_W-1] ? STEP_W'(16'd0 - delta) : STEP_W'(delta);
		job.day      = d;
		job.month    = m;
		job.year     = y;
		job.backward = delta[DELTA_W-1];
		job.steps    = (32'(mag) > 32'(MAX_DELTA)) ? STEP_W'(MAX_DELTA) : mag;
		job.ok       = date_ok;
	end

endmodule

// ----- src/gdad_queue.sv -----
module gdad_queue
	import gdad_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t rd_job
);

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	job_t            mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CntW'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/gdad_back.sv -----
module gdad_back
	import gdad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	input  job_t                  job,
	output logic                  job_pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// end_day[4:0], end_month[8:5], end_year[22:9], zero[23]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// start_valid[0], range_error[1]
	output logic [OUT_USER_W-1:0] m_tuser
);

	back_state_t        state_q;
	back_state_t        state_d;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic               back_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               ok_q;
	logic               err_q;

	logic               out_valid_q;
	logic [DAY_W-1:0]   out_day_q;
	logic [MONTH_W-1:0] out_month_q;
	logic [YEAR_W-1:0]  out_year_q;
	logic               out_ok_q;
	logic               out_err_q;

	logic               leap;
	logic [DAY_W-1:0]   dim_cur;
	logic [DAY_W-1:0]   dim_prev;
	logic [DAY_W-1:0]   nxt_day;
	logic [MONTH_W-1:0] nxt_month;
	logic [YEAR_W-1:0]  nxt_year;
	logic               step_err;
	logic               cnt_zero;
	logic               load_out;

	// One calendar day forward or backward from the current date.
	always_comb begin
		leap      = is_leap(year_q);
		dim_cur   = month_days(month_q, leap);
		dim_prev  = month_days(month_q - 1'b1, leap);
		nxt_day   = day_q;
		nxt_month = month_q;
		nxt_year  = year_q;
		step_err  = 1'b0;
		if (!back_q) begin
			priority if (day_q < dim_cur) begin
				nxt_day = day_q + 1'b1;
			end else if (month_q < MONTH_DEC) begin
				nxt_day   = DAY_FIRST;
				nxt_month = month_q + 1'b1;
			end else if (year_q < YEAR_MAX) begin
				nxt_day   = DAY_FIRST;
				nxt_month = MONTH_JAN;
				nxt_year  = year_q + 1'b1;
			end else begin
				step_err = 1'b1;
			end
		end else begin
			priority if (day_q > DAY_FIRST) begin
				nxt_day = day_q - 1'b1;
			end else if (month_q > MONTH_JAN) begin
				nxt_month = month_q - 1'b1;
				nxt_day   = dim_prev;
			end else if (year_q > YEAR_MIN) begin
				nxt_year  = year_q - 1'b1;
				nxt_month = MONTH_DEC;
				nxt_day   = DAY_31;
			end else begin
				step_err = 1'b1;
			end
		end
	end

	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = job.ok ? ST_RUN : ST_DONE;
				end
			end
			ST_RUN: begin
				if (cnt_zero || step_err) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		job_pop  = (state_q == ST_IDLE) && job_valid;
		load_out = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			back_q <= job.backward;
			cnt_q  <= job.steps;
			ok_q   <= job.ok;
			if (job.ok) begin
				day_q   <= job.day;
				month_q <= job.month;
				year_q  <= job.year;
				err_q   <= 1'b0;
			end else begin
				day_q   <= DAY_FIRST;
				month_q <= MONTH_JAN;
				year_q  <= YEAR_MIN;
				err_q   <= 1'b1;
			end
		end else if (state_q == ST_RUN && !cnt_zero) begin
			if (step_err) begin
				err_q <= 1'b1;
			end else begin
				day_q   <= nxt_day;
				month_q <= nxt_month;
				year_q  <= nxt_year;
				cnt_q   <= cnt_q - 1'b1;
			end
		end
		if (load_out) begin
			out_day_q   <= day_q;
			out_month_q <= month_q;
			out_year_q  <= year_q;
			out_ok_q    <= ok_q;
			out_err_q   <= err_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_year_q, out_month_q, out_day_q};
	assign m_tuser  = {out_err_q, out_ok_q};

endmodule

// ----- src/gregorian_date_add_days.sv -----
// Stepping: an accepted input beat is moved by up to N calendar days, where
// N is the saturated magnitude of day_delta (at most MAX_DELTA, 32767 by default); a start
// date that fails the check skips the stepping and goes straight to the output register.
// The date stepper takes a new job only once the last one has gone to the output register.
// Reset: arst_n is asynchronous and active low; it empties the input queue, returns the
// stepper to idle and drops m_tvalid. Date and payload registers are not reset.
module gregorian_date_add_days
	import gdad_pkg::*;
#(
	parameter int unsigned MAX_DELTA = MAX_DELTA_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// start_day[4:0], start_month[8:5], start_year[22:9], day_delta[38:23], zero[39]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// end_day[4:0], end_month[8:5], end_year[22:9], zero[23]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// start_valid[0], range_error[1]
	output logic [OUT_USER_W-1:0] m_tuser
);

	// The front end checks the start date against the 4/100/400 leap rule and
	// turns the signed count into a direction and a saturated step count. That
	// job waits in a short queue, so new beats are taken while the stepper is
	// still busy with an earlier one.
	logic push;
	logic queue_full;
	job_t front_job;
	logic job_valid;
	logic job_pop;
	job_t back_job;

	gdad_front #(
		.MAX_DELTA (MAX_DELTA)
	) u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.queue_full (queue_full),
		.push       (push),
		.job        (front_job)
	);

	gdad_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (front_job),
		.full      (queue_full),
		.pop       (job_pop),
		.not_empty (job_valid),
		.rd_job    (back_job)
	);

	// The back end walks the calendar one day per cycle, stopping early at
	// 31 Dec 9999 or 1 Jan 1 with range_error set. An invalid start date goes
	// straight to the result as 1 Jan 1 with start_valid low. The finished
	// date sits in an output register, so the stepper can pick up the next
	// job while that beat waits for m_tready.
	gdad_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (back_job),
		.job_pop   (job_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
